// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by rms_threshold_event_capture_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/core/rtec_pkg.sv =====
// ----------------------------------------------------------------------------
// rtec_pkg
// Constants for the threshold event capture unit.
// ----------------------------------------------------------------------------
package rtec_pkg;
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;
   localparam logic [0:0] REG_N_SIGMA = 1'b0;
   localparam logic [0:0] REG_WINDOW_LEN = 1'b1;
   localparam int SUM_BITS = 44;
   localparam int MIN_WINDOW = 32;
endpackage

// ===== rtl/core/rms_threshold_event_capture_unit.sv =====
// ----------------------------------------------------------------------------
// rms_threshold_event_capture_unit
// N-sigma transient detector with delay line and event window capture.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// req_     | in        | tdata: command, sample_re, sample_im, window_index
// rsp_     | out       | tdata: out_re, out_im, event_res, event_position,
//          |           |        peak_power, block_power_sum
// csr_     | in        | register index, write data
//
// A read word passes S_RD, S_RD2 and S_OUT; a push passes S_SQ1, S_SQ2 and
// S_TR2, then S_OUT if unarmed, or if armed S_TRD, S_TSQ1, S_TSQ2, S_CMP1,
// S_CMP2 and S_OUT, through one shared multiplier that forms the squares, the
// squared threshold and the compare products in turn. An event adds S_CPY and
// S_CPY2 per window sample for the copy through the delay line memory port.
// After reset a clearing pass zeroes the delay line and the event window; no
// word is taken meanwhile. The result waits in an output register; the next
// word is taken in the cycle after the result is gone.
module rms_threshold_event_capture_unit #(
   parameter int BUFFER_DEPTH = 8192,
   parameter int WINDOW_MAX = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[0], sample_re[16:1], sample_im[32:17], window_index[44:33]
   input  logic [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_re[15:0], out_im[31:16], event_res[32], event_position[45:33],
   // peak_power[77:46], block_power_sum[121:78]
   output logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);
   import rtec_pkg::*;
   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int WW = $clog2(WINDOW_MAX);

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_RD2 = 4'd3,
      S_SQ1 = 4'd4, S_SQ2 = 4'd5, S_TRD = 4'd6, S_TR2 = 4'd7, S_TSQ1 = 4'd8,
      S_TSQ2 = 4'd9, S_CMP1 = 4'd10, S_CMP2 = 4'd11, S_CPY = 4'd12,
      S_CPY2 = 4'd13, S_OUT = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [31:0] dl_mem [BUFFER_DEPTH];
   logic [31:0] ew_mem [WINDOW_MAX];
   logic [31:0] dl_q_ff, ew_q_ff;
   logic [AW-1:0] wp_ff, pos_ff, src_ff, clr_ff;
   logic [WW:0] k_ff;
   logic [SUM_BITS-1:0] rsum_ff, lsum_ff;
   logic [12:0] bcnt_ff;
   logic armed_ff;
   logic [15:0] nsig_ff;
   logic [12:0] wlen_ff;
   logic [47:0] req_ff;
   logic [31:0] acc_ff;
   logic [63:0] lhs_ff;
   logic [31:0] r2_ff;
   logic [31:0] ns2_ff;
   logic [47:0] rlo_ff;
   logic [127:0] rsp_ff;
   logic rsp_v_ff;

   // Shared multiplier: one operand pair per cycle, chosen by state.
   logic [31:0] ma, mb;
   logic [63:0] mp;
   logic signed [15:0] sa;
   logic [WW:0] n_eff;
   logic [12:0] n_cl;

   always_comb begin
      n_cl = (wlen_ff < 13'(MIN_WINDOW)) ? 13'(MIN_WINDOW) : wlen_ff;
      n_eff = (32'(n_cl) > WINDOW_MAX) ? (WW+1)'(WINDOW_MAX) : (WW+1)'(n_cl);
   end

   always_comb begin
      sa = '0; ma = '0; mb = '0;
      unique case (state_ff)
         S_SQ1: sa = req_ff[16:1];
         S_SQ2: sa = req_ff[32:17];
         S_TSQ1: sa = dl_q_ff[15:0];
         S_TSQ2: sa = dl_q_ff[31:16];
         default: sa = '0;
      endcase
      ma = 32'(sa < 0 ? -32'(sa) : 32'(sa));
      mb = ma;
      if (state_ff == S_TR2) begin
         ma = 32'(nsig_ff);
         mb = 32'(nsig_ff);
      end else if (state_ff == S_TRD) begin
         ma = ns2_ff;
         mb = 32'(lsum_ff[15:0]);
      end else if (state_ff == S_CMP1) begin
         ma = acc_ff;
         mb = 32'(n_eff);
      end else if (state_ff == S_CMP2) begin
         ma = ns2_ff;
         mb = 32'(lsum_ff[SUM_BITS-1:16]);
      end
   end
   assign mp = 64'(ma) * 64'(mb);

   logic req_fire, rsp_fire;
   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_v_ff && rsp_tready;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_ff;

   logic [AW-1:0] wp_next;
   assign wp_next = wp_ff + 1'b1;

   logic [SUM_BITS:0] sum_add;
   logic [31:0] mag2;
   assign mag2 = r2_ff + mp[31:0];
   assign sum_add = (SUM_BITS+1)'(rsum_ff) + (SUM_BITS+1)'(mag2);

   // Exact compare: big*n*65536 > ns2*lsum. lhs is big*n (<=2^43). The
   // right side is split at bit 16 of lsum: the low product is formed
   // earlier, the high product is on the multiplier in the compare cycle.
   logic hit;
   assign hit = ({lhs_ff, 16'h0} > ({mp, 16'h0} + 80'(rlo_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; clr_ff <= '0; wp_ff <= '0; rsum_ff <= '0; lsum_ff <= '0;
         bcnt_ff <= '0; armed_ff <= 1'b0; nsig_ff <= 16'd1280; wlen_ff <= 13'd1024;
         rsp_v_ff <= 1'b0;
      end else begin
         if (rsp_fire) rsp_v_ff <= 1'b0;
         if (csr_we) begin
            if (csr_index == REG_N_SIGMA) nsig_ff <= csr_wdata;
            else begin
               wlen_ff <= csr_wdata[12:0]; wp_ff <= '0; armed_ff <= 1'b0;
            end
         end
         state_ff <= state_in;
         unique case (state_ff)
            S_CLR: begin
               dl_mem[clr_ff] <= '0;
               if (32'(clr_ff) < WINDOW_MAX) ew_mem[WW'(clr_ff)] <= '0;
               clr_ff <= clr_ff + 1'b1;
            end
            S_IDLE: if (req_fire) req_ff <= req_tdata;
            S_RD: ew_q_ff <= ew_mem[req_ff[33+WW-1:33]];
            S_RD2: begin
               rsp_ff <= {96'd0, (32'(req_ff[44:33]) < WINDOW_MAX) ? ew_q_ff : 32'd0};
            end
            S_SQ1: begin
               r2_ff <= mp[31:0];
               dl_mem[wp_ff] <= req_ff[32:1];
            end
            S_SQ2: begin
               logic [SUM_BITS-1:0] ns;
               ns = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
               rsp_ff <= {96'd0, req_ff[32:1]};
               if (bcnt_ff + 1'b1 >= 13'(n_eff)) begin
                  lsum_ff <= ns; rsum_ff <= '0; bcnt_ff <= '0; armed_ff <= 1'b1;
               end else begin
                  rsum_ff <= ns; bcnt_ff <= bcnt_ff + 1'b1;
               end
               wp_ff <= wp_next;
               pos_ff <= wp_next + AW'(n_eff >> 1) + 1'b1;
            end
            S_TR2: ns2_ff <= mp[31:0];
            S_TRD: begin
               dl_q_ff <= dl_mem[pos_ff];
               rlo_ff <= mp[47:0];
            end
            S_TSQ1: r2_ff <= mp[31:0];
            S_TSQ2: begin
               acc_ff <= (r2_ff > mp[31:0]) ? r2_ff : mp[31:0];
               peak_sum: r2_ff <= r2_ff + mp[31:0];
            end
            S_CMP1: lhs_ff <= mp;
            S_CMP2: if (hit) begin
               rsum_ff <= '0; bcnt_ff <= '0; armed_ff <= 1'b0;
               src_ff <= pos_ff - AW'(n_eff >> 1); k_ff <= '0;
               rsp_ff[77:32] <= {r2_ff, 13'(pos_ff), 1'b1};
            end
            S_CPY: begin
               dl_q_ff <= dl_mem[src_ff]; src_ff <= src_ff + 1'b1;
            end
            S_CPY2: begin
               ew_mem[k_ff[WW-1:0]] <= dl_q_ff; k_ff <= k_ff + 1'b1;
            end
            S_OUT: begin
               rsp_ff[121:78] <= lsum_ff; rsp_v_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: if (32'(clr_ff) == BUFFER_DEPTH - 1) state_in = S_IDLE;
         S_IDLE: if (req_fire) state_in = (req_tdata[0] == CMD_READ) ? S_RD : S_SQ1;
         S_RD: state_in = S_RD2;
         S_RD2: state_in = S_OUT;
         S_SQ1: state_in = S_SQ2;
         S_SQ2: state_in = S_TR2;
         S_TR2: state_in = armed_ff ? S_TRD : S_OUT;
         S_TRD: state_in = S_TSQ1;
         S_TSQ1: state_in = S_TSQ2;
         S_TSQ2: state_in = S_CMP1;
         S_CMP1: state_in = S_CMP2;
         S_CMP2: state_in = hit ? S_CPY : S_OUT;
         S_CPY: state_in = S_CPY2;
         S_CPY2: state_in = (k_ff + 1'b1 == n_eff) ? S_OUT : S_CPY;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

`include "assert_macros.svh"
   `ASSERT_IMPLIES(a_no_take_busy, clock, reset, req_tvalid && req_tready, !rsp_v_ff)
   `ASSERT_NEXT(a_out_idle, clock, reset, state_ff == S_OUT, rsp_v_ff)
   `ASSERT_IMPLIES(a_copy_len, clock, reset, state_ff == S_CPY2, k_ff < n_eff)
endmodule
